// File: hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and tables for the Euler-to-quaternion core.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W    = 18;
  localparam int TRIG_W     = 32;
  localparam int ZW         = 33;
  localparam int ATAN_N     = 24;
  localparam int PHASE_DIV  = 45;
  localparam int FRAC_W     = 20;
  localparam int LANE_LAT   = 4;
  localparam int MERGE_LAT  = 6;

  localparam logic [ANGLE_W:0] HALF_TURN = 19'd184320;
  localparam logic [18:0]      RECIP_45  = 19'd372828;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sincos_t;

  typedef logic [31:0] atan_tbl_t [ATAN_N];
  localparam atan_tbl_t ATAN_TBL = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic [FRAC_W-1:0] frac_tbl_t [64];

  function automatic frac_tbl_t build_frac();
    frac_tbl_t t;
    longint v;
    for (int r = 0; r < 64; r++) begin
      if (r < PHASE_DIV) begin
        v = ((longint'(r) << 20) + 22) / PHASE_DIV;
        t[r] = v[FRAC_W-1:0];
      end else begin
        t[r] = '0;
      end
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac();

endpackage

// File: hdl/e2q_lane.sv
// ----------------------------------------------------------------------------
// e2q_lane
// One angle lane: half-angle phase reduction, quadrant fold and a pipelined
// rotation-mode CORDIC giving cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module e2q_lane import e2q_pkg::*; #(
  parameter int RUN = 16
) (
  input  logic                      clk,
  input  logic signed [ANGLE_W-1:0] angle,
  output sincos_t                   sc
);

  logic [ANGLE_W-1:0] u_1;
  logic [11:0]        q_1;
  logic [11:0]        q_2;
  logic [5:0]         r_2;
  logic [ANGLE_W-1:0] u_c;
  logic [36:0]        prod_c;
  logic [17:0]        m45_c;
  logic [31:0]        ph_c;
  logic [ZW-1:0]      z_c;
  logic               neg_c;

  logic signed [TRIG_W-1:0] cx [RUN+1];
  logic signed [TRIG_W-1:0] cy [RUN+1];
  logic signed [ZW-1:0]     cz [RUN+1];
  logic                     cn [RUN+1];

  always_comb begin
    logic [ANGLE_W:0] t;
    t      = {angle[ANGLE_W-1], angle} + HALF_TURN;
    u_c    = angle[ANGLE_W-1] ? t[ANGLE_W-1:0] : angle;
    prod_c = u_c * RECIP_45;
  end

  always_ff @(posedge clk) begin
    u_1 <= u_c;
    q_1 <= prod_c[35:24];
  end

  always_comb begin
    m45_c = ({6'd0, q_1} << 5) + ({6'd0, q_1} << 3) + ({6'd0, q_1} << 2) + {6'd0, q_1};
  end

  always_ff @(posedge clk) begin
    q_2 <= q_1;
    r_2 <= 6'(u_1 - m45_c);
  end

  always_comb begin
    ph_c  = {q_2, FRAC_TBL[r_2]};
    neg_c = 1'b0;
    z_c   = {ph_c[31], ph_c};
    if ((!ph_c[31] && ph_c > 32'h4000_0000) ||
        (ph_c[31] && ph_c < 32'hC000_0000)) begin
      neg_c = 1'b1;
      z_c   = {~ph_c[31], ~ph_c[31], ph_c[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    cx[0] <= CORDIC_GAIN;
    cy[0] <= '0;
    cz[0] <= z_c;
    cn[0] <= neg_c;
  end

  for (genvar i = 0; i < RUN; i++) begin : g_stage
    logic signed [ZW-1:0] at;
    assign at = $signed({1'b0, ATAN_TBL[i]});
    always_ff @(posedge clk) begin
      if (!cz[i][ZW-1]) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - at;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + at;
      end
      cn[i+1] <= cn[i];
    end
  end

  always_ff @(posedge clk) begin
    sc.c <= cn[RUN] ? -cx[RUN] : cx[RUN];
    sc.s <= cn[RUN] ? -cy[RUN] : cy[RUN];
  end

endmodule

// File: hdl/e2q_merge.sv
// ----------------------------------------------------------------------------
// e2q_merge
// Combines the three lanes' half-angle cosines and sines into the four
// quaternion components: pair products, triple products, sums, output
// rounding and saturation.
// ----------------------------------------------------------------------------
module e2q_merge import e2q_pkg::*; #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk,
  input  sincos_t                     pitch,
  input  sincos_t                     yaw,
  input  sincos_t                     roll,
  output logic signed [OUT_WIDTH-1:0] quat_w,
  output logic signed [OUT_WIDTH-1:0] quat_x,
  output logic signed [OUT_WIDTH-1:0] quat_y,
  output logic signed [OUT_WIDTH-1:0] quat_z
);

  localparam int PW = 34;
  localparam int SW = 35;
  localparam int VW = 36;

  // pair order: cr*cp, sr*sp, sr*cp, cr*sp
  logic signed [63:0]   pp [4];
  logic signed [PW-1:0] pr [4];
  trig_t                cy1, sy1, cy2, sy2;
  logic signed [65:0]   t1 [4];
  logic signed [65:0]   t2 [4];
  logic signed [PW-1:0] r1 [4];
  logic signed [PW-1:0] r2 [4];
  logic signed [SW-1:0] sm [4];
  logic signed [OUT_WIDTH-1:0] qo [4];

  always_ff @(posedge clk) begin
    pp[0] <= roll.c * pitch.c;
    pp[1] <= roll.s * pitch.s;
    pp[2] <= roll.s * pitch.c;
    pp[3] <= roll.c * pitch.s;
    cy1   <= yaw.c;
    sy1   <= yaw.s;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pr[k] <= PW'((pp[k] + 64'sd536870912) >>> 30);
    end
    cy2 <= cy1;
    sy2 <= sy1;
  end

  always_ff @(posedge clk) begin
    t1[0] <= pr[0] * cy2;
    t2[0] <= pr[1] * sy2;
    t1[1] <= pr[2] * cy2;
    t2[1] <= pr[3] * sy2;
    t1[2] <= pr[3] * cy2;
    t2[2] <= pr[2] * sy2;
    t1[3] <= pr[0] * sy2;
    t2[3] <= pr[1] * cy2;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      r1[k] <= PW'((t1[k] + 66'sd536870912) >>> 30);
      r2[k] <= PW'((t2[k] + 66'sd536870912) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    sm[0] <= SW'(r1[0]) + SW'(r2[0]);
    sm[1] <= SW'(r1[1]) - SW'(r2[1]);
    sm[2] <= SW'(r1[2]) + SW'(r2[2]);
    sm[3] <= SW'(r1[3]) - SW'(r2[3]);
  end

  localparam logic signed [VW-1:0] MAXV = VW'((64'sd1 <<< (OUT_WIDTH - 1)) - 1);
  localparam logic signed [VW-1:0] MINV = -VW'(64'sd1 <<< (OUT_WIDTH - 1));

  for (genvar k = 0; k < 4; k++) begin : g_out
    logic signed [VW-1:0] v;
    if (OUT_WIDTH - 1 > 30) begin : g_up
      assign v = VW'(sm[k]) <<< (OUT_WIDTH - 31);
    end else if (OUT_WIDTH - 1 < 30) begin : g_dn
      localparam int SH = 31 - OUT_WIDTH;
      localparam logic signed [VW-1:0] HALF = VW'(64'sd1 <<< (SH - 1));
      assign v = (VW'(sm[k]) + HALF) >>> SH;
    end else begin : g_eq
      assign v = VW'(sm[k]);
    end
    always_ff @(posedge clk) begin
      if (v > MAXV) begin
        qo[k] <= MAXV[OUT_WIDTH-1:0];
      end else if (v < MINV) begin
        qo[k] <= MINV[OUT_WIDTH-1:0];
      end else begin
        qo[k] <= v[OUT_WIDTH-1:0];
      end
    end
  end

  assign quat_w = qo[0];
  assign quat_x = qo[1];
  assign quat_y = qo[2];
  assign quat_z = qo[3];

endmodule

// File: hdl/euler_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Converts pitch, yaw and roll angles (1/256 degree) to a unit quaternion.
// ----------------------------------------------------------------------------
// A transaction is taken every cycle that start is high; busy stays low.
// Each transaction returns one quaternion on done, shown for one cycle. The
// angles pass through the phase reduction, the per-angle CORDIC pipeline
// (one stage per iteration) and the product/rounding pipeline. Results cannot
// be held off.
module euler_to_quaternion_core import e2q_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int OUT_WIDTH     = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [ANGLE_W-1:0]   pitch_angle,
  input  logic signed [ANGLE_W-1:0]   yaw_angle,
  input  logic signed [ANGLE_W-1:0]   roll_angle,
  output logic                        done,
  output logic signed [OUT_WIDTH-1:0] quat_w,
  output logic signed [OUT_WIDTH-1:0] quat_x,
  output logic signed [OUT_WIDTH-1:0] quat_y,
  output logic signed [OUT_WIDTH-1:0] quat_z
);

  localparam int RUN = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam int LAT = RUN + LANE_LAT + MERGE_LAT;

  sincos_t         sc_p, sc_y, sc_r;
  logic [LAT-1:0]  vld;

  assign busy = 1'b0;

  e2q_lane #(.RUN(RUN)) u_lane_p (.clk(clk), .angle(pitch_angle), .sc(sc_p));
  e2q_lane #(.RUN(RUN)) u_lane_y (.clk(clk), .angle(yaw_angle),   .sc(sc_y));
  e2q_lane #(.RUN(RUN)) u_lane_r (.clk(clk), .angle(roll_angle),  .sc(sc_r));

  e2q_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge (
    .clk    (clk),
    .pitch  (sc_p),
    .yaw    (sc_y),
    .roll   (sc_r),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];

endmodule

// File: hdl/e2q_checker.sv
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for the Euler-to-quaternion core, bound to the top level.
// ----------------------------------------------------------------------------
module e2q_checker import e2q_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int RUN = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam int LAT = RUN + LANE_LAT + MERGE_LAT;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transaction lost");

  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without transaction");

endmodule

bind euler_to_quaternion_core e2q_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_e2q_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
